// ===== sv/cld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_pkg
// shared types and constants of the colour-line disparity selector
// ----------------------------------------------------------------------------
package cld_pkg;

  localparam int CHUNK_W = 32;  // operand width of the shared multiplier
  localparam int SH_W    = 8;   // product alignment shift, covers every legal configuration
  localparam int TIX_W   = 2;   // chunk index width

  localparam int NTERM = 6;
  localparam int NPROD = 5;

  // covariance term slots
  localparam logic [2:0] T_C00 = 3'd0;
  localparam logic [2:0] T_C11 = 3'd1;
  localparam logic [2:0] T_C22 = 3'd2;
  localparam logic [2:0] T_C01 = 3'd3;
  localparam logic [2:0] T_C12 = 3'd4;
  localparam logic [2:0] T_C02 = 3'd5;

  // determinant product slots
  localparam logic [2:0] P_DEN  = 3'd0;
  localparam logic [2:0] P_OFF  = 3'd1;
  localparam logic [2:0] P_LAST = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_EDGE_LO = 2'd0;
  localparam logic [1:0] CFG_EDGE_HI = 2'd1;
  localparam logic [1:0] CFG_RADIUS  = 2'd2;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_MUL,
    ALU_CLR_TMP,
    ALU_CLR_DET,
    ALU_DEN,
    ALU_CMP,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    alu_op_t              op;
    logic                 tmp_src;
    logic                 dest_det;
    logic                 sub;
    logic [SH_W-1:0]      sh;
    logic [TIX_W-1:0]     tix;
    logic [CHUNK_W-1:0]   opa;
    logic [CHUNK_W-1:0]   opb;
  } alu_ctl_t;

  typedef struct packed {
    logic det_neg;
    logic ge;
  } alu_sts_t;

  typedef struct packed {
    logic [21:0]        sum_red;
    logic [21:0]        sum_green;
    logic [21:0]        sum_blue;
    logic [21:0]        sumsq_red;
    logic [21:0]        sumsq_green;
    logic [21:0]        sumsq_blue;
    logic [21:0]        cross_red_green;
    logic [21:0]        cross_green_blue;
    logic [21:0]        cross_blue_red;
    logic signed [6:0]  disparity;
    logic               last_disparity;
  } item_t;

  typedef struct packed {
    logic signed [6:0] best_disparity;
    logic [15:0]       best_error;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CM1, S_CM2, S_CDRN, S_CCAP, S_ZCHK,
    S_LA, S_LB, S_LC, S_PAB, S_PD1, S_PC, S_PD2,
    S_DEN, S_SIGN, S_CMP, S_DIV, S_DQ, S_UPD
  } seq_state_t;

  // covariance term used by slot of a determinant product
  function automatic logic [2:0] prod_idx(input logic [2:0] p, input logic [1:0] slot);
    logic [2:0] r;
    r = T_C00;
    case (p)
      3'd0: begin
        case (slot)
          2'd0:    r = T_C00;
          2'd1:    r = T_C11;
          default: r = T_C22;
        endcase
      end
      3'd1: begin
        case (slot)
          2'd0:    r = T_C01;
          2'd1:    r = T_C12;
          default: r = T_C02;
        endcase
      end
      3'd2: begin
        case (slot)
          2'd1:    r = T_C11;
          default: r = T_C02;
        endcase
      end
      3'd3: begin
        case (slot)
          2'd2:    r = T_C22;
          default: r = T_C01;
        endcase
      end
      default: begin
        case (slot)
          2'd0:    r = T_C00;
          default: r = T_C12;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

// ===== sv/colour_line_disparity_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colour_line_disparity_select
// per-pixel colour-line disparity selection over a run of candidate items
// ----------------------------------------------------------------------------
// Items for one pixel arrive one per candidate disparity; the item with
// in_tlast high closes the pixel and yields one result item carrying the
// disparity of smallest colour-line error, that error as unsigned Q0.16 and
// a usable flag that drops when the winner sits on either range edge.
// The block takes one item at a time: one shared 32x32 multiplier with one
// wide accumulate adder does all the arithmetic under a sequencer, which
// skips the determinant when a diagonal covariance term is zero and the
// division when the determinant is negative or saturates. The 16 quotient
// bits come from restoring division steps on the same adder.
// On a pixel's last item the sequencer also waits until the output register
// is free. Results wait in an output register, so the next item is taken
// while a result is still unclaimed.
// ----------------------------------------------------------------------------
module colour_line_disparity_select
  import cld_pkg::*;
#(
  parameter int FRACTION_BITS = 12,
  parameter int MAX_RADIUS    = 15
) (
  input  logic         clk,
  input  logic         rst_n,
  // sum_red, sum_green, sum_blue, sumsq_red, sumsq_green, sumsq_blue,
  // cross_red_green, cross_green_blue, cross_blue_red, disparity, zero pad
  input  logic [207:0] in_tdata,
  input  logic         in_tlast,   // last_disparity
  input  logic         in_tvalid,
  output logic         in_tready,
  // best_disparity, best_error, zero pad
  output logic [23:0]  out_tdata,
  output logic         out_tuser,  // valid_res
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [5:0]   cfg_wdata
);

  localparam int RW  = $clog2(MAX_RADIUS + 1);
  localparam int AW  = 2 * (RW + 1);
  localparam int MW  = (FRACTION_BITS + 22 + AW > 44) ? FRACTION_BITS + 22 + AW : 44;
  localparam int DW  = 3*MW + 4;

  // configuration registers
  logic signed [5:0] dmin_r;
  logic [5:0]        dmax_r;
  logic [3:0]        wrad_r;

  // output register
  logic        out_valid_r, out_valid_nxt;
  res_t        out_res_r;
  logic        out_ok_r;

  logic [RW-1:0] rad;
  logic [RW:0]   side;
  logic [AW-1:0] area;
  item_t         item;
  alu_ctl_t      ctl;
  alu_sts_t      sts;
  logic [DW-1:0] tmp;
  logic [15:0]   quot;
  logic          out_free, res_v, res_ok;
  res_t          res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dmin_r <= -6'sd8;
      dmax_r <= 6'd8;
      wrad_r <= 4'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EDGE_LO: dmin_r <= cfg_wdata;
        CFG_EDGE_HI: dmax_r <= cfg_wdata;
        CFG_RADIUS:  wrad_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // radius saturates, area = (2r+1)^2
  assign rad  = (32'(wrad_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(wrad_r);
  assign side = {rad, 1'b1};
  assign area = AW'(side) * AW'(side);

  // unpack the input item
  assign item.sum_red          = in_tdata[21:0];
  assign item.sum_green        = in_tdata[43:22];
  assign item.sum_blue         = in_tdata[65:44];
  assign item.sumsq_red        = in_tdata[87:66];
  assign item.sumsq_green      = in_tdata[109:88];
  assign item.sumsq_blue       = in_tdata[131:110];
  assign item.cross_red_green  = in_tdata[153:132];
  assign item.cross_green_blue = in_tdata[175:154];
  assign item.cross_blue_red   = in_tdata[197:176];
  assign item.disparity        = in_tdata[204:198];
  assign item.last_disparity   = in_tlast;

  cld_seq #(
    .FRACTION_BITS (FRACTION_BITS),
    .AREA_W        (AW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .item_i   (item),
    .area_i   (area),
    .ctl      (ctl),
    .tmp_i    (tmp),
    .sts      (sts),
    .q_i      (quot),
    .out_free (out_free),
    .res_v    (res_v),
    .res      (res)
  );

  cld_alu #(
    .MAG_W (MW)
  ) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .tmp_o (tmp),
    .sts   (sts),
    .q_o   (quot)
  );

  // edge check against the range registers
  assign res_ok = !((8'(res.best_disparity) == 8'(dmin_r)) ||
                    ($signed(8'(res.best_disparity)) == $signed({2'b00, dmax_r})));

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_v) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_v) begin
      out_res_r <= res;
      out_ok_r  <= res_ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.best_error, out_res_r.best_disparity};
  assign out_tuser  = out_ok_r;

  // a result is only loaded when the output slot is free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_v |-> out_free) else $error("result loaded over a pending item");

  // no new item is taken in the cycle a result is issued
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_v && in_tready)) else $error("item accepted while result issued");

  // a loaded result shows up on the output
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    res_v |=> out_valid_r) else $error("loaded result not presented");

endmodule

// ===== sv/cld_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_alu
// shared 32x32 multiplier with a registered product, one wide adder that
// accumulates products and runs restoring division steps
// ----------------------------------------------------------------------------
module cld_alu
  import cld_pkg::*;
#(
  parameter int MAG_W = 45
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  alu_ctl_t                ctl,
  output logic [3*MAG_W+3:0]      tmp_o,
  output alu_sts_t                sts,
  output logic [15:0]             q_o
);

  localparam int DW  = 3*MAG_W + 4;
  localparam int NT  = (2*MAG_W + CHUNK_W - 1) / CHUNK_W;
  localparam int TPW = NT * CHUNK_W;

  logic [DW-1:0]        tmp_r, tmp_nxt;
  logic [DW-1:0]        det_r, det_nxt;
  logic [DW-1:0]        den_r, den_nxt;
  logic [15:0]          q_r, q_nxt;
  logic [2*CHUNK_W-1:0] prod_r, prod_nxt;
  logic [SH_W-1:0]      psh_r;
  logic                 pdest_r, psub_r;
  logic                 pv_r;

  logic [TPW-1:0]     tmp_ext;
  logic [CHUNK_W-1:0] opa_sel;
  logic [DW-1:0]      addend, add_a, add_b, sum;
  logic               dv, cmp, do_sub;

  assign tmp_ext = TPW'(tmp_r[2*MAG_W-1:0]);
  assign opa_sel = ctl.tmp_src ? tmp_ext[ctl.tix*CHUNK_W +: CHUNK_W] : ctl.opa;
  assign prod_nxt = (2*CHUNK_W)'(opa_sel) * (2*CHUNK_W)'(ctl.opb);

  assign dv     = (ctl.op == ALU_DIV);
  assign cmp    = (ctl.op == ALU_CMP);
  assign addend = DW'(prod_r) << psh_r;

  always_comb begin
    if (dv) begin
      add_a = det_r << 1;
    end else if (cmp || pdest_r) begin
      add_a = det_r;
    end else begin
      add_a = tmp_r;
    end
    add_b  = (dv || cmp) ? den_r : addend;
    do_sub = (dv || cmp) ? 1'b1 : psub_r;
    sum    = do_sub ? add_a - add_b : add_a + add_b;
  end

  always_comb begin
    tmp_nxt = tmp_r;
    det_nxt = det_r;
    den_nxt = den_r;
    q_nxt   = q_r;
    if (ctl.op == ALU_CLR_TMP) begin
      tmp_nxt = '0;
    end else if (pv_r && !pdest_r) begin
      tmp_nxt = sum;
    end
    if (ctl.op == ALU_CLR_DET) begin
      det_nxt = '0;
    end else if (pv_r && pdest_r) begin
      det_nxt = sum;
    end else if (dv) begin
      det_nxt = sum[DW-1] ? det_r << 1 : sum;
    end
    if (ctl.op == ALU_DEN) begin
      den_nxt = det_r;
    end
    if (dv) begin
      q_nxt = {q_r[14:0], ~sum[DW-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= (ctl.op == ALU_MUL);
    end
  end

  always_ff @(posedge clk) begin
    tmp_r <= tmp_nxt;
    det_r <= det_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
    if (ctl.op == ALU_MUL) begin
      prod_r  <= prod_nxt;
      psh_r   <= ctl.sh;
      pdest_r <= ctl.dest_det;
      psub_r  <= ctl.sub;
    end
  end

  assign tmp_o       = tmp_r;
  assign q_o         = q_r;
  assign sts.det_neg = det_r[DW-1];
  assign sts.ge      = ~sum[DW-1];

endmodule

// ===== sv/cld_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cld_seq
// sequencer: covariance terms, determinant products, division and the
// running minimum over the candidates of one pixel
// ----------------------------------------------------------------------------
module cld_seq
  import cld_pkg::*;
#(
  parameter int FRACTION_BITS = 12,
  parameter int AREA_W        = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  item_t                  item_i,
  input  logic [AREA_W-1:0]      area_i,
  output alu_ctl_t               ctl,
  input  logic [3*((FRACTION_BITS+22+AREA_W > 44) ? FRACTION_BITS+22+AREA_W : 44)+3:0] tmp_i,
  input  alu_sts_t               sts,
  input  logic [15:0]            q_i,
  input  logic                   out_free,
  output logic                   res_v,
  output res_t                   res
);

  localparam int MW  = (FRACTION_BITS + 22 + AREA_W > 44) ? FRACTION_BITS + 22 + AREA_W : 44;
  localparam int DW  = 3*MW + 4;
  localparam int NM  = (MW + CHUNK_W - 1) / CHUNK_W;
  localparam int NT  = (2*MW + CHUNK_W - 1) / CHUNK_W;
  localparam int MPW = NM * CHUNK_W;

  seq_state_t        st_r, st_nxt;
  item_t             item_r, item_nxt;
  logic [2:0]        t_r, t_nxt;
  logic [2:0]        p_r, p_nxt;
  logic [TIX_W-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic [3:0]        dcnt_r, dcnt_nxt;
  logic [MW-1:0]     mag_r [NTERM];
  logic              neg_r [NTERM];
  logic [MW-1:0]     oa_r, ob_r, oc_r;
  logic              sgn_r, sgn_nxt;
  logic [15:0]       err_r, err_nxt;
  logic [15:0]       best_err_r, best_err_nxt;
  logic signed [6:0] best_disp_r, best_disp_nxt;
  logic              have_r, have_nxt;

  logic [21:0]       q_sel, sa_sel, sb_sel;
  logic [DW-1:0]     cov_abs;
  logic              cov_neg;
  logic [MPW-1:0]    oa_ext, ob_ext, oc_ext;
  logic [2:0]        sel_idx;
  logic              take;
  logic              last_i, last_j;
  logic [SH_W-1:0]   chunk_sh;

  assign oa_ext   = MPW'(oa_r);
  assign ob_ext   = MPW'(ob_r);
  assign oc_ext   = MPW'(oc_r);
  assign cov_neg  = tmp_i[DW-1];
  assign cov_abs  = cov_neg ? DW'(-tmp_i) : tmp_i;
  assign chunk_sh = SH_W'(CHUNK_W) * (SH_W'(i_r) + SH_W'(j_r));
  assign take     = !have_r || (err_r < best_err_r);
  assign sel_idx  = prod_idx(p_r, (st_r == S_LA) ? 2'd0 : (st_r == S_LB) ? 2'd1 : 2'd2);

  always_comb begin
    case (t_r)
      T_C00: begin q_sel = item_r.sumsq_red;        sa_sel = item_r.sum_red;   sb_sel = item_r.sum_red;   end
      T_C11: begin q_sel = item_r.sumsq_green;      sa_sel = item_r.sum_green; sb_sel = item_r.sum_green; end
      T_C22: begin q_sel = item_r.sumsq_blue;       sa_sel = item_r.sum_blue;  sb_sel = item_r.sum_blue;  end
      T_C01: begin q_sel = item_r.cross_red_green;  sa_sel = item_r.sum_red;   sb_sel = item_r.sum_green; end
      T_C12: begin q_sel = item_r.cross_green_blue; sa_sel = item_r.sum_green; sb_sel = item_r.sum_blue;  end
      default: begin
        q_sel = item_r.cross_blue_red; sa_sel = item_r.sum_red; sb_sel = item_r.sum_blue;
      end
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    item_nxt      = item_r;
    t_nxt         = t_r;
    p_nxt         = p_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    dcnt_nxt      = dcnt_r;
    sgn_nxt       = sgn_r;
    err_nxt       = err_r;
    best_err_nxt  = best_err_r;
    best_disp_nxt = best_disp_r;
    have_nxt      = have_r;
    in_ready      = 1'b0;
    res_v         = 1'b0;
    res.best_disparity = take ? item_r.disparity : best_disp_r;
    res.best_error     = take ? err_r : best_err_r;
    last_i        = 1'b0;
    last_j        = 1'b0;
    ctl           = '0;
    ctl.op        = ALU_NOP;

    case (st_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt = item_i;
          t_nxt    = T_C00;
          ctl.op   = ALU_CLR_TMP;
          st_nxt   = S_CM1;
        end
      end
      // q * area aligned by the fraction bits
      S_CM1: begin
        ctl.op  = ALU_MUL;
        ctl.opa = CHUNK_W'(q_sel);
        ctl.opb = CHUNK_W'(area_i);
        ctl.sh  = SH_W'(FRACTION_BITS);
        st_nxt  = S_CM2;
      end
      S_CM2: begin
        ctl.op  = ALU_MUL;
        ctl.opa = CHUNK_W'(sa_sel);
        ctl.opb = CHUNK_W'(sb_sel);
        ctl.sub = 1'b1;
        st_nxt  = S_CDRN;
      end
      S_CDRN: st_nxt = S_CCAP;
      S_CCAP: begin
        ctl.op = ALU_CLR_TMP;
        if (t_r == T_C02) begin
          st_nxt = S_ZCHK;
        end else begin
          t_nxt  = t_r + 3'd1;
          st_nxt = S_CM1;
        end
      end
      S_ZCHK: begin
        if (mag_r[T_C00] == '0 || mag_r[T_C11] == '0 || mag_r[T_C22] == '0) begin
          err_nxt = '0;
          st_nxt  = S_UPD;
        end else begin
          ctl.op = ALU_CLR_DET;
          p_nxt  = P_DEN;
          st_nxt = S_LA;
        end
      end
      S_LA: begin
        ctl.op  = ALU_CLR_TMP;
        sgn_nxt = (p_r > P_OFF) ^ neg_r[sel_idx];
        st_nxt  = S_LB;
      end
      S_LB: begin
        sgn_nxt = sgn_r ^ neg_r[sel_idx];
        st_nxt  = S_LC;
      end
      S_LC: begin
        sgn_nxt = sgn_r ^ neg_r[sel_idx];
        i_nxt   = '0;
        j_nxt   = '0;
        st_nxt  = S_PAB;
      end
      S_PAB: begin
        ctl.op  = ALU_MUL;
        ctl.opa = oa_ext[i_r*CHUNK_W +: CHUNK_W];
        ctl.opb = ob_ext[j_r*CHUNK_W +: CHUNK_W];
        ctl.sh  = chunk_sh;
        last_i  = (i_r == TIX_W'(NM-1));
        last_j  = (j_r == TIX_W'(NM-1));
        if (last_j) begin
          j_nxt = '0;
          i_nxt = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
        if (last_i && last_j) begin
          st_nxt = S_PD1;
        end
      end
      S_PD1: begin
        i_nxt  = '0;
        j_nxt  = '0;
        st_nxt = S_PC;
      end
      // running product times the third term, into the determinant
      S_PC: begin
        ctl.op       = ALU_MUL;
        ctl.tmp_src  = 1'b1;
        ctl.tix      = i_r;
        ctl.opb      = oc_ext[j_r*CHUNK_W +: CHUNK_W];
        ctl.dest_det = 1'b1;
        ctl.sub      = sgn_r;
        ctl.sh       = chunk_sh + SH_W'(p_r == P_OFF);
        last_i       = (i_r == TIX_W'(NT-1));
        last_j       = (j_r == TIX_W'(NM-1));
        if (last_j) begin
          j_nxt = '0;
          i_nxt = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
        if (last_i && last_j) begin
          st_nxt = S_PD2;
        end
      end
      S_PD2: begin
        if (p_r == P_DEN) begin
          st_nxt = S_DEN;
        end else if (p_r == P_LAST) begin
          st_nxt = S_SIGN;
        end else begin
          p_nxt  = p_r + 3'd1;
          st_nxt = S_LA;
        end
      end
      S_DEN: begin
        ctl.op = ALU_DEN;
        p_nxt  = P_OFF;
        st_nxt = S_LA;
      end
      S_SIGN: begin
        if (sts.det_neg) begin
          err_nxt = '0;
          st_nxt  = S_UPD;
        end else begin
          st_nxt = S_CMP;
        end
      end
      S_CMP: begin
        ctl.op = ALU_CMP;
        if (sts.ge) begin
          err_nxt = 16'hFFFF;
          st_nxt  = S_UPD;
        end else begin
          dcnt_nxt = '0;
          st_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        ctl.op   = ALU_DIV;
        dcnt_nxt = dcnt_r + 4'd1;
        if (dcnt_r == 4'd15) begin
          st_nxt = S_DQ;
        end
      end
      S_DQ: begin
        err_nxt = q_i;
        st_nxt  = S_UPD;
      end
      S_UPD: begin
        if (item_r.last_disparity) begin
          if (out_free) begin
            res_v         = 1'b1;
            best_err_nxt  = '0;
            best_disp_nxt = '0;
            have_nxt      = 1'b0;
            st_nxt        = S_IDLE;
          end
        end else begin
          best_err_nxt  = res.best_error;
          best_disp_nxt = res.best_disparity;
          have_nxt      = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      best_err_r  <= '0;
      best_disp_r <= '0;
      have_r      <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      best_err_r  <= best_err_nxt;
      best_disp_r <= best_disp_nxt;
      have_r      <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    t_r    <= t_nxt;
    p_r    <= p_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    dcnt_r <= dcnt_nxt;
    sgn_r  <= sgn_nxt;
    err_r  <= err_nxt;
    if (st_r == S_CCAP) begin
      // diagonal terms clamp at zero
      if (t_r < T_C01 && cov_neg) begin
        mag_r[t_r] <= '0;
        neg_r[t_r] <= 1'b0;
      end else begin
        mag_r[t_r] <= cov_abs[MW-1:0];
        neg_r[t_r] <= cov_neg;
      end
    end
    if (st_r == S_LA) oa_r <= mag_r[sel_idx];
    if (st_r == S_LB) ob_r <= mag_r[sel_idx];
    if (st_r == S_LC) oc_r <= mag_r[sel_idx];
  end

endmodule
